FILE: hdl/vts_pkg.sv
// shared types, codes and helpers for the vtol transition supervisor
package vts_pkg;

  // elapsed-tick counter width (8 to 64)
  localparam int TICK_WIDTH = 32;
  localparam int LIMIT_WIDTH = 32;
  localparam int CMP_WIDTH = (TICK_WIDTH > LIMIT_WIDTH) ? TICK_WIDTH : LIMIT_WIDTH;

  typedef logic [TICK_WIDTH-1:0] tick_t;
  localparam tick_t TICK_MAX = '1;

  // common width for the timeout compare
  typedef logic [CMP_WIDTH-1:0] cmp_t;

  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_OBSERVE  = 3'd0;
  localparam cmd_t CMD_REQUEST  = 3'd1;
  localparam cmd_t CMD_ACK_OK   = 3'd2;
  localparam cmd_t CMD_XPORT_NG = 3'd3;
  localparam cmd_t CMD_ACK_REJ  = 3'd4;
  localparam cmd_t CMD_TICK     = 3'd5;

  typedef logic [2:0] reason_t;
  localparam reason_t RSN_NONE        = 3'd0;
  localparam reason_t RSN_NOT_VTOL    = 3'd1;
  localparam reason_t RSN_TARGET_NONE = 3'd2;
  localparam reason_t RSN_SAME_PEND   = 3'd3;
  localparam reason_t RSN_OPPOS_PEND  = 3'd4;
  localparam reason_t RSN_ACTIVE      = 3'd5;
  localparam reason_t RSN_ILLEGAL_SRC = 3'd6;
  localparam reason_t RSN_NOW_PENDING = 3'd7;

  typedef logic [2:0] regime_t;
  localparam regime_t RGM_UNKNOWN  = 3'd0;
  localparam regime_t RGM_HOVER    = 3'd1;
  localparam regime_t RGM_TO_FWD   = 3'd2;
  localparam regime_t RGM_FORWARD  = 3'd3;
  localparam regime_t RGM_TO_HOVER = 3'd4;

  typedef logic [1:0] target_t;
  localparam target_t TGT_NONE    = 2'd0;
  localparam target_t TGT_HOVER   = 2'd1;
  localparam target_t TGT_FORWARD = 2'd2;

  typedef logic [2:0] outcome_t;
  localparam outcome_t OUT_NONE      = 3'd0;
  localparam outcome_t OUT_ACCEPTED  = 3'd1;
  localparam outcome_t OUT_COMPLETED = 3'd2;
  localparam outcome_t OUT_XPORT_NG  = 3'd3;
  localparam outcome_t OUT_REJECTED  = 3'd4;
  localparam outcome_t OUT_TIMED_OUT = 3'd5;

  // reported vehicle state codes
  localparam logic [7:0] VS_TO_FWD   = 8'd1;
  localparam logic [7:0] VS_TO_HOVER = 8'd2;
  localparam logic [7:0] VS_HOVER    = 8'd3;
  localparam logic [7:0] VS_FORWARD  = 8'd4;

  localparam int PADDR_WIDTH = 3;
  typedef logic [PADDR_WIDTH-1:0] paddr_t;

  function automatic regime_t map_state(input logic [7:0] s);
    regime_t r;
    r = RGM_UNKNOWN;
    if (s == VS_TO_FWD)   r = RGM_TO_FWD;
    if (s == VS_TO_HOVER) r = RGM_TO_HOVER;
    if (s == VS_HOVER)    r = RGM_HOVER;
    if (s == VS_FORWARD)  r = RGM_FORWARD;
    return r;
  endfunction

  // the regime that a target settles in
  function automatic logic at_target(input target_t t, input regime_t r);
    return ((t == TGT_FORWARD) && (r == RGM_FORWARD)) ||
           ((t == TGT_HOVER) && (r == RGM_HOVER));
  endfunction

  // the steady regime from which a target may be requested
  function automatic logic start_allowed(input target_t t, input regime_t r);
    return ((t == TGT_FORWARD) && (r == RGM_HOVER)) ||
           ((t == TGT_HOVER) && (r == RGM_FORWARD));
  endfunction

endpackage

FILE: hdl/vtol_transition_supervisor_top.sv
// vtol transition supervisor: input register, decision logic, result register
// an accepted input word goes through the input register and then the result register to the output
// throughput: one word per cycle; the input register refills in the cycle the
//   result register empties, so only a stalled output holds the input back
// reset (rst, synchronous): both stages empty, supervisor status cleared,
//   is_vtol set to 1 and timeout_ticks cleared to 0
module vtol_transition_supervisor_top (
  input  logic                            clk,
  input  logic                            rst,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vts_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // event input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      command,
  input  logic [7:0]                      vtol_state,
  input  logic                            state_recent,
  input  logic [1:0]                      requested_regime,
  input  logic [7:0]                      ack_code,
  // status output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            ok,
  output logic [2:0]                      reason_code,
  output logic [2:0]                      regime,
  output logic                            is_pending,
  output logic [1:0]                      current_target,
  output logic [1:0]                      previous_target,
  output logic [2:0]                      outcome,
  output logic                            ack_seen,
  output logic                            expired,
  output logic [7:0]                      last_ack
);

  // configuration registers
  logic        is_vtol;
  logic [31:0] timeout_ticks;

  // input register
  logic                 held;
  vts_pkg::cmd_t        h_command;
  logic [7:0]           h_vtol_state;
  logic                 h_state_recent;
  vts_pkg::target_t     h_requested;
  logic [7:0]           h_ack_code;

  // supervisor state
  vts_pkg::regime_t  regime_reg,   regime_next;
  logic              pending_reg,  pending_next;
  vts_pkg::target_t  target_reg,   target_next;
  vts_pkg::target_t  prev_reg,     prev_next;
  vts_pkg::outcome_t outcome_reg,  outcome_next;
  logic              ack_seen_reg, ack_seen_next;
  logic              expired_reg,  expired_next;
  logic [7:0]        ack_code_reg, ack_code_next;
  vts_pkg::tick_t    elapsed,      elapsed_next;

  logic              ok_next;
  vts_pkg::reason_t  reason_next;
  vts_pkg::regime_t  seen_regime;
  logic              advance;
  logic              cfg_write;

  // apb: zero-wait, word index on paddr[2]
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_vtol       <= 1'b1;
      timeout_ticks <= '0;
    end else if (cfg_write) begin
      if (paddr[2]) begin
        timeout_ticks <= pwdata;
      end else begin
        is_vtol <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2]) begin
      prdata = timeout_ticks;
    end else begin
      prdata = {31'd0, is_vtol};
    end
  end

  // the held word moves on when the result register is free or being emptied
  assign advance  = held && (!out_valid || out_ready);
  assign in_ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      h_command      <= command;
      h_vtol_state   <= vtol_state;
      h_state_recent <= state_recent;
      h_requested    <= requested_regime;
      h_ack_code     <= ack_code;
    end
  end

  // decision logic for the held word
  always_comb begin
    regime_next   = regime_reg;
    pending_next  = pending_reg;
    target_next   = target_reg;
    prev_next     = prev_reg;
    outcome_next  = outcome_reg;
    ack_seen_next = ack_seen_reg;
    expired_next  = expired_reg;
    ack_code_next = ack_code_reg;
    elapsed_next  = elapsed;
    ok_next       = 1'b0;
    reason_next   = vts_pkg::RSN_NONE;
    seen_regime   = vts_pkg::map_state(h_vtol_state);

    unique case (h_command)
      vts_pkg::CMD_OBSERVE: begin
        if (!h_state_recent || !is_vtol) begin
          regime_next = vts_pkg::RGM_UNKNOWN;
        end else begin
          regime_next = seen_regime;
          // pending request completes once its target regime is seen
          if (pending_reg && vts_pkg::at_target(target_reg, seen_regime)) begin
            pending_next = 1'b0;
            prev_next    = target_reg;
            target_next  = vts_pkg::TGT_NONE;
            outcome_next = vts_pkg::OUT_COMPLETED;
            ok_next      = 1'b1;
          end
        end
      end
      vts_pkg::CMD_REQUEST: begin
        priority if (!is_vtol) begin
          reason_next = vts_pkg::RSN_NOT_VTOL;
        end else if (h_requested != vts_pkg::TGT_HOVER &&
                     h_requested != vts_pkg::TGT_FORWARD) begin
          // none, and the unused code three
          reason_next = vts_pkg::RSN_TARGET_NONE;
        end else if (pending_reg) begin
          if (target_reg == h_requested) begin
            reason_next = vts_pkg::RSN_SAME_PEND;
            ok_next     = 1'b1;
          end else begin
            reason_next = vts_pkg::RSN_OPPOS_PEND;
          end
        end else if (vts_pkg::at_target(h_requested, regime_reg)) begin
          reason_next = vts_pkg::RSN_ACTIVE;
          ok_next     = 1'b1;
        end else if (vts_pkg::start_allowed(h_requested, regime_reg)) begin
          // new request: status cleared, counter restarts
          pending_next  = 1'b1;
          target_next   = h_requested;
          prev_next     = vts_pkg::TGT_NONE;
          outcome_next  = vts_pkg::OUT_NONE;
          ack_seen_next = 1'b0;
          expired_next  = 1'b0;
          ack_code_next = '0;
          elapsed_next  = '0;
          reason_next   = vts_pkg::RSN_NOW_PENDING;
          ok_next       = 1'b1;
        end else begin
          reason_next = vts_pkg::RSN_ILLEGAL_SRC;
        end
      end
      vts_pkg::CMD_ACK_OK: begin
        ack_seen_next = 1'b1;
        ack_code_next = h_ack_code;
        outcome_next  = vts_pkg::OUT_ACCEPTED;
      end
      vts_pkg::CMD_XPORT_NG: begin
        ack_seen_next = 1'b0;
        pending_next  = 1'b0;
        prev_next     = target_reg;
        target_next   = vts_pkg::TGT_NONE;
        outcome_next  = vts_pkg::OUT_XPORT_NG;
      end
      vts_pkg::CMD_ACK_REJ: begin
        ack_seen_next = 1'b0;
        ack_code_next = h_ack_code;
        pending_next  = 1'b0;
        prev_next     = target_reg;
        target_next   = vts_pkg::TGT_NONE;
        outcome_next  = vts_pkg::OUT_REJECTED;
      end
      vts_pkg::CMD_TICK: begin
        // saturating count, then the timeout check on the new count
        if (elapsed != vts_pkg::TICK_MAX) begin
          elapsed_next = elapsed + 1'b1;
        end
        if (pending_reg && (timeout_ticks != '0) &&
            (vts_pkg::cmp_t'(elapsed_next) > vts_pkg::cmp_t'(timeout_ticks))) begin
          expired_next = 1'b1;
          pending_next = 1'b0;
          prev_next    = target_reg;
          target_next  = vts_pkg::TGT_NONE;
          outcome_next = vts_pkg::OUT_TIMED_OUT;
          ok_next      = 1'b1;
        end
      end
      default: begin
        // unused command codes leave the status alone
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regime_reg   <= vts_pkg::RGM_UNKNOWN;
      pending_reg  <= 1'b0;
      target_reg   <= vts_pkg::TGT_NONE;
      prev_reg     <= vts_pkg::TGT_NONE;
      outcome_reg  <= vts_pkg::OUT_NONE;
      ack_seen_reg <= 1'b0;
      expired_reg  <= 1'b0;
      ack_code_reg <= '0;
      elapsed      <= '0;
    end else if (advance) begin
      regime_reg   <= regime_next;
      pending_reg  <= pending_next;
      target_reg   <= target_next;
      prev_reg     <= prev_next;
      outcome_reg  <= outcome_next;
      ack_seen_reg <= ack_seen_next;
      expired_reg  <= expired_next;
      ack_code_reg <= ack_code_next;
      elapsed      <= elapsed_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ok              <= ok_next;
      reason_code     <= reason_next;
      regime          <= regime_next;
      is_pending      <= pending_next;
      current_target  <= target_next;
      previous_target <= prev_next;
      outcome         <= outcome_next;
      ack_seen        <= ack_seen_next;
      expired         <= expired_next;
      last_ack        <= ack_code_next;
    end
  end

endmodule

FILE: hdl/vts_checker.sv
// port-level checks for the vtol transition supervisor, bound to the top level
module vts_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       ok,
  input logic [2:0] reason_code,
  input logic [2:0] regime,
  input logic       is_pending,
  input logic [1:0] current_target,
  input logic [2:0] outcome,
  input logic       expired,
  input logic [7:0] last_ack
);

  // no word comes out straight after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result word present right after reset");

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(reason_code) &&
      $stable(regime) && $stable(outcome) && $stable(last_ack))
    else $error("stalled result word changed");

  // pending and target travel together
  a_pend_target: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_pending == (current_target != vts_pkg::TGT_NONE)))
    else $error("pending flag and target disagree");

  // a timed-out outcome always carries the expired mark
  a_timeout_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == vts_pkg::OUT_TIMED_OUT |-> expired)
    else $error("timed-out outcome without expired mark");

  // a request that goes pending starts from a cleared status
  a_new_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && reason_code == vts_pkg::RSN_NOW_PENDING |->
      ok && is_pending && outcome == vts_pkg::OUT_NONE && !expired && last_ack == 8'd0)
    else $error("new pending request with stale status");

endmodule

bind vtol_transition_supervisor_top vts_checker u_vts_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .ok             (ok),
  .reason_code    (reason_code),
  .regime         (regime),
  .is_pending     (is_pending),
  .current_target (current_target),
  .outcome        (outcome),
  .expired        (expired),
  .last_ack       (last_ack)
);
